[rtl/core/arb_pkg.sv]
// Shared constants, sine table and stage types for the arc bounding rectangle core.
package arb_pkg;

  localparam int SINE_FRACTION_BITS = 15;
  localparam int SINE_SHIFT = 15 - SINE_FRACTION_BITS;

  localparam int SINE_ENTRIES = 91;

  localparam logic [15:0] SINE_Q15 [0:SINE_ENTRIES-1] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // sine operand slots
  localparam logic [1:0] S_SA  = 2'd0;  // sin(start)
  localparam logic [1:0] S_SAC = 2'd1;  // sin(start + 90)
  localparam logic [1:0] S_EA  = 2'd2;  // sin(end)
  localparam logic [1:0] S_EAC = 2'd3;  // sin(end + 90)

  // radius slots
  localparam logic R_OUT = 1'b0;
  localparam logic R_IN  = 1'b1;

  typedef enum logic [3:0] {
    K_WHOLE,
    K_Q0,
    K_Q1,
    K_Q2,
    K_Q3,
    K_01,
    K_12,
    K_23,
    K_30
  } kind_t;

  typedef struct packed {
    logic t01_ea;
    logic r12_sa;
    logic l30_ea;
  } pick_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        orad;
    logic signed [15:0] irad;
    logic [14:0]        inf;
    kind_t              kind;
    logic [3:0][6:0]    idx;
    logic [3:0]         neg;
  } stage_a_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        orad;
    logic signed [15:0] irad;
    logic [14:0]        inf;
    kind_t              kind;
    logic [3:0][16:0]   sine;
    pick_t              pick;
  } stage_b_t;

  typedef struct packed {
    logic signed [15:0]    x;
    logic signed [15:0]    y;
    logic [14:0]           orad;
    logic [14:0]           inf;
    kind_t                 kind;
    logic [3:0][1:0][16:0] sc;
  } stage_c_t;

  function automatic logic [15:0] sine_q15(input logic [6:0] idx);
    logic [15:0] v;
    v = 16'd0;
    if (idx < 7'(SINE_ENTRIES)) begin
      v = SINE_Q15[idx];
    end
    return v;
  endfunction

endpackage

[rtl/core/arb_if.sv]
// Stream interfaces for arc beats in and rectangle beats out.
interface arb_arc_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [14:0]        outer_radius;
  logic [9:0]         start_deg;
  logic [9:0]         end_deg;
  logic [14:0]        stroke_width;
  logic               round_caps;

  modport source (
    output valid, origin_x, origin_y, outer_radius, start_deg, end_deg,
           stroke_width, round_caps,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, outer_radius, start_deg, end_deg,
           stroke_width, round_caps,
    output ready
  );
endinterface

interface arb_rect_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] left;
  logic signed [17:0] top;
  logic signed [17:0] right;
  logic signed [17:0] bottom;

  modport source (output valid, left, top, right, bottom, input ready);
  modport sink (input valid, left, top, right, bottom, output ready);
endinterface

[rtl/core/arb_angle.sv]
// Stage 1: angle reduction, quadrant case decode and sine table indexing.
module arb_angle (
  input  logic            clk,
  input  logic            rst,
  arb_arc_if.sink         arc,
  output logic            out_valid,
  input  logic            out_ready,
  output arb_pkg::stage_a_t out_data
);
  import arb_pkg::*;

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } sidx_t;

  function automatic sidx_t sine_index(input logic [9:0] a);
    logic [9:0] m;
    sidx_t      s;
    m = a;
    if (a >= 10'd720) begin
      m = a - 10'd720;
    end else if (a >= 10'd360) begin
      m = a - 10'd360;
    end
    if (m < 10'd90) begin
      s.neg = 1'b0;
      s.idx = 7'(m);
    end else if (m < 10'd180) begin
      s.neg = 1'b0;
      s.idx = 7'(10'd180 - m);
    end else if (m < 10'd270) begin
      s.neg = 1'b1;
      s.idx = 7'(m - 10'd180);
    end else begin
      s.neg = 1'b1;
      s.idx = 7'(10'd360 - m);
    end
    return s;
  endfunction

  // 360 lands in quadrant 3
  function automatic logic [2:0] quadrant(input logic [9:0] a);
    logic [2:0] q;
    if (a >= 10'd630) begin
      q = 3'd7;
    end else if (a >= 10'd540) begin
      q = 3'd6;
    end else if (a >= 10'd450) begin
      q = 3'd5;
    end else if (a >= 10'd270) begin
      q = 3'd3;
    end else if (a >= 10'd180) begin
      q = 3'd2;
    end else if (a >= 10'd90) begin
      q = 3'd1;
    end else begin
      q = 3'd0;
    end
    return q;
  endfunction

  logic       full;
  logic [9:0] sa;
  logic [9:0] ea;
  logic [2:0] sq;
  logic [2:0] eq;
  logic       same;
  sidx_t      si [4];
  stage_a_t   a_next;

  assign full = 11'(arc.end_deg) == 11'(arc.start_deg) + 11'd360;
  assign sa   = (arc.start_deg > 10'd360) ? arc.start_deg - 10'd360 : arc.start_deg;
  assign ea   = (arc.end_deg > 10'd360) ? arc.end_deg - 10'd360 : arc.end_deg;
  assign sq   = quadrant(sa);
  assign eq   = quadrant(ea);
  assign same = (sq == eq) && (sa <= ea);

  assign si[S_SA]  = sine_index(sa);
  assign si[S_SAC] = sine_index(sa + 10'd90);
  assign si[S_EA]  = sine_index(ea);
  assign si[S_EAC] = sine_index(ea + 10'd90);

  always_comb begin
    a_next.x    = arc.origin_x;
    a_next.y    = arc.origin_y;
    a_next.orad = arc.outer_radius;
    a_next.irad = 16'({1'b0, arc.outer_radius}) - 16'({1'b0, arc.stroke_width});
    a_next.inf  = arc.round_caps ? (arc.stroke_width >> 1) + 15'd1 : 15'd0;
    for (int i = 0; i < 4; i++) begin
      a_next.idx[i] = si[i].idx;
      a_next.neg[i] = si[i].neg;
    end
    priority if (full) begin
      a_next.kind = K_WHOLE;
    end else if (same && sq == 3'd0) begin
      a_next.kind = K_Q0;
    end else if (same && sq == 3'd1) begin
      a_next.kind = K_Q1;
    end else if (same && sq == 3'd2) begin
      a_next.kind = K_Q2;
    end else if (same && sq == 3'd3) begin
      a_next.kind = K_Q3;
    end else if (same) begin
      a_next.kind = K_WHOLE;
    end else if (sq == 3'd0 && eq == 3'd1) begin
      a_next.kind = K_01;
    end else if (sq == 3'd1 && eq == 3'd2) begin
      a_next.kind = K_12;
    end else if (sq == 3'd2 && eq == 3'd3) begin
      a_next.kind = K_23;
    end else if (sq == 3'd3 && eq == 3'd0) begin
      a_next.kind = K_30;
    end else begin
      a_next.kind = K_WHOLE;
    end
  end

  assign arc.ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (arc.ready) begin
      out_valid <= arc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (arc.valid && arc.ready) begin
      out_data <= a_next;
    end
  end

endmodule

[rtl/core/arb_sine.sv]
// Stage 2: sine table lookup, sign, and min/max operand picks.
module arb_sine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  arb_pkg::stage_a_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output arb_pkg::stage_b_t out_data
);
  import arb_pkg::*;

  logic signed [16:0] sn [4];
  stage_b_t           b_next;

  always_comb begin
    logic [15:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag   = sine_q15(in_data.idx[i]) >> SINE_SHIFT;
      sn[i] = in_data.neg[i] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  always_comb begin
    b_next.x    = in_data.x;
    b_next.y    = in_data.y;
    b_next.orad = in_data.orad;
    b_next.irad = in_data.irad;
    b_next.inf  = in_data.inf;
    b_next.kind = in_data.kind;
    for (int i = 0; i < 4; i++) begin
      b_next.sine[i] = sn[i];
    end
    b_next.pick.t01_ea = sn[S_EA] < sn[S_SA];
    b_next.pick.r12_sa = sn[S_SAC] > sn[S_EAC];
    b_next.pick.l30_ea = sn[S_EAC] < sn[S_SAC];
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= b_next;
    end
  end

endmodule

[rtl/core/arb_mult.sv]
// Stage 3: sine times radius products with floor shift.
module arb_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  arb_pkg::stage_b_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output arb_pkg::stage_c_t out_data
);
  import arb_pkg::*;

  logic signed [15:0] rad [2];
  stage_c_t           c_next;

  assign rad[R_OUT] = 16'({1'b0, in_data.orad});
  assign rad[R_IN]  = in_data.irad;

  always_comb begin
    logic signed [32:0] prod;
    c_next.x    = in_data.x;
    c_next.y    = in_data.y;
    c_next.orad = in_data.orad;
    c_next.inf  = in_data.inf;
    c_next.kind = in_data.kind;
    // pick flags only matter for the selection, resolved into sc slots below
    for (int s = 0; s < 4; s++) begin
      for (int r = 0; r < 2; r++) begin
        prod = $signed(in_data.sine[s]) * rad[r];
        c_next.sc[s][r] = 17'(prod >>> SINE_FRACTION_BITS);
      end
    end
    if (in_data.kind == K_01 && !in_data.pick.t01_ea) begin
      c_next.sc[S_EA][R_IN] = c_next.sc[S_SA][R_IN];
    end
    if (in_data.kind == K_12 && !in_data.pick.r12_sa) begin
      c_next.sc[S_SAC][R_IN] = c_next.sc[S_EAC][R_IN];
    end
    if (in_data.kind == K_30 && !in_data.pick.l30_ea) begin
      c_next.sc[S_EAC][R_IN] = c_next.sc[S_SAC][R_IN];
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= c_next;
    end
  end

endmodule

[rtl/core/arb_select.sv]
// Stage 4: per-case edge selection, offset by center and cap inflation.
module arb_select (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  arb_pkg::stage_c_t in_data,
  arb_rect_if.source        rect
);
  import arb_pkg::*;

  logic signed [18:0] x;
  logic signed [18:0] y;
  logic signed [18:0] o;
  logic signed [18:0] inf;
  logic signed [18:0] tl;
  logic signed [18:0] tt;
  logic signed [18:0] tr;
  logic signed [18:0] tb;
  logic signed [18:0] sum_l;
  logic signed [18:0] sum_t;
  logic signed [18:0] sum_r;
  logic signed [18:0] sum_b;
  logic               valid;
  logic [17:0]        left;
  logic [17:0]        top;
  logic [17:0]        right;
  logic [17:0]        bottom;

  function automatic logic signed [18:0] ext(input logic [16:0] v);
    return 19'($signed(v));
  endfunction

  assign x   = 19'(in_data.x);
  assign y   = 19'(in_data.y);
  assign o   = 19'({4'd0, in_data.orad});
  assign inf = (in_data.kind == K_WHOLE) ? 19'sd0 : 19'({4'd0, in_data.inf});

  always_comb begin
    tl = -o;
    tt = -o;
    tr = o;
    tb = o;
    unique case (in_data.kind)
      K_Q0: begin
        tt = ext(in_data.sc[S_SA][R_IN]);
        tr = ext(in_data.sc[S_SAC][R_OUT]);
        tb = ext(in_data.sc[S_EA][R_OUT]);
        tl = ext(in_data.sc[S_EAC][R_IN]);
      end
      K_Q1: begin
        tb = ext(in_data.sc[S_SA][R_OUT]);
        tr = ext(in_data.sc[S_SAC][R_IN]);
        tt = ext(in_data.sc[S_EA][R_IN]);
        tl = ext(in_data.sc[S_EAC][R_OUT]);
      end
      K_Q2: begin
        tl = ext(in_data.sc[S_SAC][R_OUT]);
        tb = ext(in_data.sc[S_SA][R_IN]);
        tt = ext(in_data.sc[S_EA][R_OUT]);
        tr = ext(in_data.sc[S_EAC][R_IN]);
      end
      K_Q3: begin
        tl = ext(in_data.sc[S_SAC][R_IN]);
        tt = ext(in_data.sc[S_SA][R_OUT]);
        tr = ext(in_data.sc[S_EAC][R_OUT]);
        tb = ext(in_data.sc[S_EA][R_IN]);
      end
      K_01: begin
        tl = ext(in_data.sc[S_EAC][R_OUT]);
        tt = ext(in_data.sc[S_EA][R_IN]);
        tr = ext(in_data.sc[S_SAC][R_OUT]);
      end
      K_12: begin
        tt = ext(in_data.sc[S_EA][R_OUT]);
        tr = ext(in_data.sc[S_SAC][R_IN]);
        tb = ext(in_data.sc[S_SA][R_OUT]);
      end
      K_23: begin
        tl = ext(in_data.sc[S_SAC][R_OUT]);
        tr = ext(in_data.sc[S_EAC][R_OUT]);
        tb = ($signed(in_data.sc[S_EA][R_IN]) > $signed(in_data.sc[S_SA][R_IN])) ?
             ext(in_data.sc[S_EA][R_IN]) : ext(in_data.sc[S_SA][R_IN]);
      end
      K_30: begin
        tl = ext(in_data.sc[S_EAC][R_IN]);
        tt = ext(in_data.sc[S_SA][R_OUT]);
        tb = ext(in_data.sc[S_EA][R_OUT]);
      end
      default: begin
      end
    endcase
  end

  assign sum_l = x + tl - inf;
  assign sum_t = y + tt - inf;
  assign sum_r = x + tr + inf;
  assign sum_b = y + tb + inf;

  assign in_ready = ~valid | rect.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      left   <= sum_l[17:0];
      top    <= sum_t[17:0];
      right  <= sum_r[17:0];
      bottom <= sum_b[17:0];
    end
  end

  assign rect.valid  = valid;
  assign rect.left   = left;
  assign rect.top    = top;
  assign rect.right  = right;
  assign rect.bottom = bottom;

endmodule

[rtl/core/arc_bounding_rect_core.sv]
// Arc bounding rectangle core: four-stage pipeline from arc beat to rectangle beat.
// Datapath: each arc beat passes through four register stages (angle, sine, mult, select)
// before its rectangle beat is handed off; the first stage loads at the accepting edge.
// Throughput: one arc per cycle; each stage holds one beat, and a stage takes a new
// beat whenever it is empty or its beat moves on, so output stalls back up stage by stage.
// Critical stage: the 17x16 sine-by-radius multipliers in stage 3.
// Reset: synchronous rst clears all stage valid bits; data registers are not reset.
module arc_bounding_rect_core (
  input  logic       clk,
  input  logic       rst,
  arb_arc_if.sink    arc,
  arb_rect_if.source rect
);
  import arb_pkg::*;

  logic     a_valid;
  logic     a_ready;
  stage_a_t a_data;
  logic     b_valid;
  logic     b_ready;
  stage_b_t b_data;
  logic     c_valid;
  logic     c_ready;
  stage_c_t c_data;

  arb_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .arc       (arc),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_data  (a_data)
  );

  arb_sine u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_data   (a_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  arb_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_data   (b_data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  arb_select u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid),
    .in_ready (c_ready),
    .in_data  (c_data),
    .rect     (rect)
  );

endmodule
